// ===== rtl/ssh_pkg.sv =====
// shared types for the skyline sweep heap block
// controller commands, datapath status and state enum; no dependencies
package ssh_pkg;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_OP,
        ST_INS_RD,
        ST_INS_WR,
        ST_UP_RD,
        ST_UP_WAIT,
        ST_UP_CMP,
        ST_REM_RD,
        ST_REM_WAIT,
        ST_REM_LAST,
        ST_REM_DEC,
        ST_DN_RD,
        ST_DN_WAIT,
        ST_DN_CMP,
        ST_FINAL,
        ST_TOP_RD,
        ST_TOP_WAIT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic latch_in;
        logic start_chk;
        logic pos_rd;
        logic ins_append;
        logic up_rd;
        logic up_move;
        logic rem_rd_last;
        logic rem_place;
        logic rem_drop;
        logic dn_rd;
        logic dn_move;
        logic put_final;
        logic top_rd;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic start_out;
        logic present;
        logic full;
        logic is_right;
        logic pos_is_last;
        logic pos_bad;
        logic up_go;
        logic dn_has_child;
        logic dn_go;
        logic rem_up;
        logic emit_need;
        logic out_busy;
    } t_sts;

endpackage

// ===== rtl/ssh_ctrl.sv =====
// sequencer for the skyline sweep heap block
// uses ssh_pkg types; drives datapath commands from status
module ssh_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  ssh_pkg::t_sts i_sts,
    output ssh_pkg::t_cmd o_cmd
);

    ssh_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssh_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            ssh_pkg::ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) n_state = ssh_pkg::ST_IDLE;
            end
            ssh_pkg::ST_IDLE: begin
                o_stall = 1'b0;
                o_cmd.latch_in = i_valid;
                if (i_valid) n_state = ssh_pkg::ST_START;
            end
            ssh_pkg::ST_START: begin
                if (!i_sts.out_busy) begin
                    o_cmd.start_chk = 1'b1;
                    o_cmd.pos_rd = 1'b1;
                    n_state = ssh_pkg::ST_OP;
                end
            end
            ssh_pkg::ST_OP: begin
                if (i_sts.is_right) begin
                    if (!i_sts.present || i_sts.pos_bad) begin
                        n_state = ssh_pkg::ST_TOP_RD;
                    end else begin
                        o_cmd.rem_rd_last = 1'b1;
                        n_state = ssh_pkg::ST_REM_RD;
                    end
                end else if (i_sts.present || i_sts.full) begin
                    n_state = ssh_pkg::ST_TOP_RD;
                end else begin
                    o_cmd.ins_append = 1'b1;
                    n_state = ssh_pkg::ST_UP_RD;
                end
            end
            ssh_pkg::ST_UP_RD: begin
                o_cmd.up_rd = 1'b1;
                n_state = ssh_pkg::ST_UP_WAIT;
            end
            ssh_pkg::ST_UP_WAIT: begin
                n_state = ssh_pkg::ST_UP_CMP;
            end
            ssh_pkg::ST_UP_CMP: begin
                if (i_sts.up_go) begin
                    o_cmd.up_move = 1'b1;
                    n_state = ssh_pkg::ST_UP_RD;
                end else begin
                    n_state = ssh_pkg::ST_FINAL;
                end
            end
            ssh_pkg::ST_REM_RD: begin
                n_state = ssh_pkg::ST_REM_WAIT;
            end
            ssh_pkg::ST_REM_WAIT: begin
                if (i_sts.pos_is_last) begin
                    o_cmd.rem_drop = 1'b1;
                    n_state = ssh_pkg::ST_TOP_RD;
                end else begin
                    n_state = ssh_pkg::ST_REM_LAST;
                end
            end
            ssh_pkg::ST_REM_LAST: begin
                o_cmd.rem_place = 1'b1;
                n_state = ssh_pkg::ST_REM_DEC;
            end
            ssh_pkg::ST_REM_DEC: begin
                n_state = i_sts.rem_up ? ssh_pkg::ST_UP_RD : ssh_pkg::ST_DN_RD;
            end
            ssh_pkg::ST_DN_RD: begin
                if (i_sts.dn_has_child) begin
                    o_cmd.dn_rd = 1'b1;
                    n_state = ssh_pkg::ST_DN_WAIT;
                end else begin
                    n_state = ssh_pkg::ST_FINAL;
                end
            end
            ssh_pkg::ST_DN_WAIT: begin
                n_state = ssh_pkg::ST_DN_CMP;
            end
            ssh_pkg::ST_DN_CMP: begin
                if (i_sts.dn_go) begin
                    o_cmd.dn_move = 1'b1;
                    n_state = ssh_pkg::ST_DN_RD;
                end else begin
                    n_state = ssh_pkg::ST_FINAL;
                end
            end
            ssh_pkg::ST_FINAL: begin
                o_cmd.put_final = 1'b1;
                n_state = ssh_pkg::ST_TOP_RD;
            end
            ssh_pkg::ST_TOP_RD: begin
                o_cmd.top_rd = 1'b1;
                n_state = ssh_pkg::ST_TOP_WAIT;
            end
            ssh_pkg::ST_TOP_WAIT: begin
                n_state = ssh_pkg::ST_EMIT;
            end
            ssh_pkg::ST_EMIT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state = ssh_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ssh_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/ssh_dpath.sv =====
// heap memory, position table, sweep state and output register
// uses ssh_pkg command and status structs; driven by ssh_ctrl
module ssh_dpath #(
    parameter int MAX_BUILDINGS = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ssh_pkg::t_cmd i_cmd,
    output ssh_pkg::t_sts o_sts,
    input  logic [15:0]   i_x_pos,
    input  logic [9:0]    i_bldg_id,
    input  logic [15:0]   i_bldg_height,
    input  logic          i_is_right,
    input  logic          i_group_end,
    input  logic          i_sweep_end,
    input  logic          i_out_stall,
    output logic          o_out_valid,
    output logic [15:0]   o_point_x,
    output logic [15:0]   o_point_height,
    output logic          o_run_last
);

    localparam int PW = $clog2(MAX_BUILDINGS + 1);
    localparam int HD = MAX_BUILDINGS + 1;
    localparam int AW = $clog2(HD);

    logic [25:0]   r_heap [HD];
    logic [PW-1:0] r_pos  [1024];

    logic [15:0]   r_x, r_h;
    logic [9:0]    r_id;
    logic          r_right, r_gend, r_send;
    logic [PW-1:0] r_cnt, r_idx, r_p;
    logic [15:0]   r_prev, r_ph, r_last_top;
    logic          r_started;
    logic [10:0]   r_clr;
    logic [PW-1:0] r_posq;
    logic [25:0]   r_rda, r_rdb;
    logic [1:0]    r_ov;
    logic [15:0]   r_ox [2];
    logic [15:0]   r_oh [2];
    logic          r_ol [2];
    logic          r_start_pt;

    logic [PW-1:0] w_par, w_c, w_c1, w_child;
    logic [AW-1:0] w_ra, w_rb;
    logic          w_rd;
    logic          w_hw;
    logic [AW-1:0] w_ha;
    logic [25:0]   w_hd;
    logic          w_pw;
    logic [9:0]    w_pa;
    logic [PW-1:0] w_pd;
    logic [15:0]   w_top;
    logic          w_cnt_ok;

    assign w_par = r_idx >> 1;
    assign w_c   = {r_idx[PW-2:0], 1'b0};
    assign w_c1  = w_c + PW'(1);
    assign w_top = (r_cnt == '0) ? 16'd0 : r_rda[15:0];
    assign w_child = (w_c != r_cnt && r_rda[15:0] < r_rdb[15:0]) ? w_c1 : w_c;
    assign w_rd  = i_cmd.up_rd | i_cmd.dn_rd | i_cmd.top_rd | i_cmd.rem_rd_last;

    always_comb begin
        w_ra = AW'(w_par);
        w_rb = AW'(w_c1);
        if (i_cmd.dn_rd) w_ra = AW'(w_c);
        if (i_cmd.top_rd) w_ra = AW'(1);
        if (i_cmd.rem_rd_last) begin
            w_ra = AW'(r_cnt);
            w_rb = AW'(r_posq >> 1);
        end
    end

    always_comb begin
        w_hw = 1'b0; w_ha = AW'(r_idx); w_hd = '0;
        w_pw = 1'b0; w_pa = r_id; w_pd = r_idx;
        if (i_cmd.clr_step) begin
            w_pw = 1'b1; w_pa = r_clr[9:0]; w_pd = '0;
        end else if (i_cmd.up_move) begin
            w_hw = 1'b1; w_hd = r_rda; w_pw = 1'b1; w_pa = r_rda[25:16];
        end else if (i_cmd.dn_move) begin
            w_hw = 1'b1; w_hd = (w_child == w_c) ? r_rda : r_rdb;
            w_pw = 1'b1; w_pa = w_hd[25:16];
        end else if (i_cmd.put_final) begin
            w_hw = 1'b1; w_hd = {r_id, r_h}; w_pw = 1'b1;
        end else if (i_cmd.rem_drop) begin
            w_pw = 1'b1; w_pd = '0;
        end else if (i_cmd.rem_place) begin
            w_pw = 1'b1; w_pd = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_hw) r_heap[w_ha] <= w_hd;
        if (w_rd) begin
            r_rda <= r_heap[w_ra];
            r_rdb <= r_heap[w_rb];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pw) r_pos[w_pa] <= w_pd;
        if (i_cmd.pos_rd) r_posq <= r_pos[r_id];
    end

    assign w_cnt_ok = r_cnt < PW'(MAX_BUILDINGS);

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_x <= i_x_pos; r_id <= i_bldg_id; r_h <= i_bldg_height;
            r_right <= i_is_right; r_gend <= i_group_end; r_send <= i_sweep_end;
        end
        if (i_cmd.ins_append) r_idx <= r_cnt + PW'(1);
        if (i_cmd.up_move) r_idx <= w_par;
        if (i_cmd.dn_move) r_idx <= w_child;
        if (i_cmd.rem_rd_last) begin
            r_p <= r_posq; r_idx <= r_posq;
        end
        if (i_cmd.rem_place) begin
            r_id <= r_rda[25:16]; r_h <= r_rda[15:0];
            r_ph <= r_rdb[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0; r_cnt <= '0; r_prev <= '0; r_started <= 1'b0;
            r_ov <= '0; r_start_pt <= 1'b0;
        end else begin
            if (i_cmd.clr_step) r_clr <= r_clr + 11'd1;
            if (i_cmd.ins_append) r_cnt <= r_cnt + PW'(1);
            if (i_cmd.rem_drop || i_cmd.rem_place) r_cnt <= r_cnt - PW'(1);
            if (i_cmd.start_chk) begin
                r_start_pt <= 1'b0;
                if (!r_started) begin
                    r_started <= 1'b1;
                    r_prev <= r_last_top;
                    r_start_pt <= r_x != '0;
                end
            end
            if (i_cmd.emit) begin
                r_ov <= {1'b0, 1'b0};
                if (r_start_pt && o_sts.emit_need) begin
                    r_ov <= 2'b11;
                end else if (r_start_pt || o_sts.emit_need) begin
                    r_ov <= 2'b01;
                end
                r_ox[0] <= r_start_pt ? 16'd0 : r_x;
                r_oh[0] <= r_start_pt ? 16'd0 : w_top;
                r_ol[0] <= !(r_start_pt && o_sts.emit_need);
                r_ox[1] <= r_x; r_oh[1] <= w_top; r_ol[1] <= 1'b1;
                if (o_sts.emit_need) r_prev <= w_top;
                if (r_send) r_started <= 1'b0;
            end else if (r_ov[0] && !i_out_stall) begin
                r_ov <= {1'b0, r_ov[1]};
                r_ox[0] <= r_ox[1]; r_oh[0] <= r_oh[1]; r_ol[0] <= r_ol[1];
            end
        end
    end

    // heap top after the last event, loaded into prev at sweep start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_last_top <= '0;
        else if (i_cmd.emit) r_last_top <= w_top;
    end

    always_comb begin
        o_sts = '0;
        o_sts.clr_done    = r_clr == 11'd1023;
        o_sts.present     = r_posq != '0;
        o_sts.full        = !w_cnt_ok;
        o_sts.is_right    = r_right;
        o_sts.pos_bad     = r_cnt == '0 || r_posq > r_cnt;
        o_sts.pos_is_last = r_p == r_cnt;
        o_sts.up_go       = r_idx > PW'(1) && r_rda[15:0] < r_h;
        o_sts.dn_has_child = {1'b0, r_idx, 1'b0} <= {2'b0, r_cnt};
        o_sts.dn_go       = ((w_child == w_c) ? r_rda[15:0] : r_rdb[15:0]) > r_h;
        o_sts.rem_up      = r_p != PW'(1) && r_h > r_ph;
        o_sts.emit_need   = (r_gend || r_send) && w_top != r_prev;
        o_sts.out_busy    = r_ov[0];
        o_sts.start_out   = r_start_pt;
    end

    assign o_out_valid    = r_ov[0];
    assign o_point_x      = r_ox[0];
    assign o_point_height = r_oh[0];
    assign o_run_last     = r_ol[0];

endmodule

// ===== rtl/skyline_sweep_indexed_max_heap.sv =====
// top level of the skyline sweep heap block
// joins ssh_ctrl and ssh_dpath; uses ssh_pkg
//
// One edge event is taken at a time. After reset a clearing pass zeroes all
// 1024 position table entries while the input stalls. An ignored event skips
// the sift; an insert or remove walks the heap one level per compare step,
// reading through the single heap memory read port pair. Any event may also
// wait for the output register to drain. Results leave through a two entry
// output register.
module skyline_sweep_indexed_max_heap #(
    parameter int MAX_BUILDINGS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_x_pos,
    input  logic [9:0]  i_bldg_id,
    input  logic [15:0] i_bldg_height,
    input  logic        i_is_right,
    input  logic        i_group_end,
    input  logic        i_sweep_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_point_x,
    output logic [15:0] o_point_height,
    output logic        o_run_last
);

    ssh_pkg::t_cmd w_cmd;
    ssh_pkg::t_sts w_sts;

    ssh_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_sts  (w_sts),
        .o_cmd  (w_cmd)
    );

    ssh_dpath #(.MAX_BUILDINGS(MAX_BUILDINGS)) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_x_pos       (i_x_pos),
        .i_bldg_id     (i_bldg_id),
        .i_bldg_height (i_bldg_height),
        .i_is_right    (i_is_right),
        .i_group_end   (i_group_end),
        .i_sweep_end   (i_sweep_end),
        .i_out_stall   (i_stall),
        .o_out_valid   (o_valid),
        .o_point_x     (o_point_x),
        .o_point_height(o_point_height),
        .o_run_last    (o_run_last)
    );

`ifndef SYNTHESIS
    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |=> !o_stall)
        else $error("no return to idle after emit");
    a_no_cmd_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.up_move, w_cmd.dn_move, w_cmd.put_final, w_cmd.clr_step}))
        else $error("heap write command clash");
    a_accept_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("second beat accepted while busy");
`endif

endmodule
